/* rtl/core/pidaw_pkg.sv */
// Shared types, register indexes and reset constants for the PID anti-windup unit.
package pidaw_pkg;

    localparam int ACC_INT_BITS = 24;
    localparam int GAIN_W       = 32;
    localparam int DECAY_W      = 25;
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_INDEX_W  = 3;

    localparam logic [63:0] PROP_GAIN_RESET_Q24       = 64'd335544320;
    localparam logic [63:0] INTEGRAL_GAIN_RESET_Q24   = 64'd16777;
    localparam logic [63:0] DERIVATIVE_DECAY_RESET_Q24 = 64'd15252015;
    localparam logic [63:0] DERIVATIVE_GAIN_RESET_Q24 = 64'd152520150;
    localparam logic [63:0] WINDUP_GAIN_RESET_Q24     = 64'd167772;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PROP_GAIN        = 3'd0,
        REG_INTEGRAL_GAIN    = 3'd1,
        REG_DERIVATIVE_DECAY = 3'd2,
        REG_DERIVATIVE_GAIN  = 3'd3,
        REG_WINDUP_GAIN      = 3'd4,
        REG_OUT_LOW          = 3'd5,
        REG_OUT_HIGH         = 3'd6
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_P_GO,
        ST_P_WAIT,
        ST_DQ_GO,
        ST_DQ_WAIT,
        ST_DI_GO,
        ST_DI_WAIT,
        ST_V1,
        ST_V2,
        ST_CLAMP,
        ST_W,
        ST_II_GO,
        ST_II_WAIT,
        ST_IW_GO,
        ST_IW_WAIT,
        ST_OUT
    } pid_state_t;

    typedef enum logic [2:0] {
        MS_IDLE,
        MS_LO,
        MS_HI,
        MS_SUM,
        MS_SAT,
        MS_SIGN
    } mul_step_t;

    typedef struct packed {
        logic start;
        logic scaled;
    } mul_cmd_t;

    function automatic logic [63:0] scale_q24(input logic [63:0] value, input int frac_bits);
        if (frac_bits >= 24)
        begin
            return value << (frac_bits - 24);
        end
        return value >> (24 - frac_bits);
    endfunction

endpackage

/* rtl/core/pidaw_in_if.sv */
// Input channel carrying setpoint and measurement samples.
interface pidaw_in_if #(
    parameter int SAMPLE_WIDTH = 16
) ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] setpoint;
    logic signed [SAMPLE_WIDTH-1:0] measured;

    modport source (output valid, output setpoint, output measured, input ready);
    modport sink (input valid, input setpoint, input measured, output ready);
endinterface

/* rtl/core/pidaw_out_if.sv */
// Output channel carrying the clamped drive value.
interface pidaw_out_if #(
    parameter int SAMPLE_WIDTH = 16
) ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] drive;

    modport source (output valid, output drive, input ready);
    modport sink (input valid, input drive, output ready);
endinterface

/* rtl/core/pidaw_mul.sv */
// Multi-cycle saturating gain multiplier built around one 32x32 multiplier.
module pidaw_mul #(
    parameter  int FRAC_BITS = 24,
    localparam int ACC_W     = pidaw_pkg::ACC_INT_BITS + FRAC_BITS
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  pidaw_pkg::mul_cmd_t     cmd,
    input  logic signed [ACC_W-1:0] operand,
    input  logic [31:0]             gain,
    output logic                    done,
    output logic signed [ACC_W-1:0] result
);

    localparam int FULL_W = ACC_W + 32;

    pidaw_pkg::mul_step_t step_reg, step_next;

    logic [ACC_W-1:0]        mag_reg, mag_next;
    logic                    neg_reg, neg_next;
    logic                    scaled_reg, scaled_next;
    logic [31:0]             gain_reg, gain_next;
    logic [63:0]             prod_reg, prod_next;
    logic [FULL_W-1:0]       acc_reg, acc_next;
    logic signed [ACC_W-1:0] res_reg, res_next;
    logic                    done_reg, done_next;

    logic [31:0]       mul_a;
    logic [63:0]       product;
    logic [FULL_W-1:0] shifted;
    logic [FULL_W-1:0] limit;

    assign mul_a   = (step_reg == pidaw_pkg::MS_LO) ? mag_reg[31:0] : 32'(mag_reg[ACC_W-1:32]);
    assign product = 64'(mul_a) * 64'(gain_reg);
    assign shifted = scaled_reg ? (acc_reg >> FRAC_BITS) : acc_reg;
    assign limit   = neg_reg ? (FULL_W'(1) << (ACC_W - 1))
                             : ((FULL_W'(1) << (ACC_W - 1)) - FULL_W'(1));

    always_comb
    begin
        step_next   = step_reg;
        mag_next    = mag_reg;
        neg_next    = neg_reg;
        scaled_next = scaled_reg;
        gain_next   = gain_reg;
        prod_next   = prod_reg;
        acc_next    = acc_reg;
        res_next    = res_reg;
        done_next   = 1'b0;
        unique case (step_reg)
            pidaw_pkg::MS_IDLE:
            begin
                if (cmd.start)
                begin
                    neg_next    = operand[ACC_W-1];
                    mag_next    = operand[ACC_W-1] ? (ACC_W'(0) - ACC_W'(operand))
                                                   : ACC_W'(operand);
                    scaled_next = cmd.scaled;
                    gain_next   = gain;
                    step_next   = pidaw_pkg::MS_LO;
                end
            end
            pidaw_pkg::MS_LO:
            begin
                prod_next = product;
                step_next = pidaw_pkg::MS_HI;
            end
            pidaw_pkg::MS_HI:
            begin
                acc_next  = FULL_W'(prod_reg);
                prod_next = product;
                step_next = pidaw_pkg::MS_SUM;
            end
            pidaw_pkg::MS_SUM:
            begin
                acc_next  = acc_reg + {prod_reg[ACC_W-1:0], 32'd0};
                step_next = pidaw_pkg::MS_SAT;
            end
            pidaw_pkg::MS_SAT:
            begin
                mag_next  = (shifted > limit) ? limit[ACC_W-1:0] : shifted[ACC_W-1:0];
                step_next = pidaw_pkg::MS_SIGN;
            end
            pidaw_pkg::MS_SIGN:
            begin
                res_next  = neg_reg ? signed'(ACC_W'(0) - mag_reg) : signed'(mag_reg);
                done_next = 1'b1;
                step_next = pidaw_pkg::MS_IDLE;
            end
            default:
            begin
                step_next = pidaw_pkg::MS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= pidaw_pkg::MS_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg    <= mag_next;
        neg_reg    <= neg_next;
        scaled_reg <= scaled_next;
        gain_reg   <= gain_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        res_reg    <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

/* rtl/core/pid_antiwindup_filtered_derivative_unit.sv */
// PID controller with filtered derivative and back-calculation anti-windup.
//
// Each feedback transaction (setpoint, measured) yields one actuator transaction (drive).
// Feedback is accepted again in the cycle the drive appears: five gain products pass in
// turn through one shared 32x32 multiplier unit, and one shared saturating adder forms
// the sums. The drive sits in an output register, so a new item may start while it
// waits; a drive not yet taken stalls only the last step of the next item.
// Gains use FRAC_BITS fraction bits; internal values are 24+FRAC_BITS bit signed and
// saturate. Write the configuration registers only while the unit is idle.
module pid_antiwindup_filtered_derivative_unit #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int FRAC_BITS    = 24
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    pidaw_in_if.sink                               feedback,
    pidaw_out_if.source                            actuator,
    input  logic                                   write_en,
    input  logic [pidaw_pkg::CFG_INDEX_W-1:0]      write_index,
    input  logic [pidaw_pkg::CFG_DATA_W-1:0]       write_data
);

    localparam int ACC_W = pidaw_pkg::ACC_INT_BITS + FRAC_BITS;
    localparam int GW    = pidaw_pkg::GAIN_W;
    localparam int DW    = FRAC_BITS + 1;
    localparam int DIF_W = SAMPLE_WIDTH + 1;

    localparam logic [GW-1:0] PROP_GAIN_RESET =
        GW'(pidaw_pkg::scale_q24(pidaw_pkg::PROP_GAIN_RESET_Q24, FRAC_BITS));
    localparam logic [GW-1:0] INTEGRAL_GAIN_RESET =
        GW'(pidaw_pkg::scale_q24(pidaw_pkg::INTEGRAL_GAIN_RESET_Q24, FRAC_BITS));
    localparam logic [DW-1:0] DERIVATIVE_DECAY_RESET =
        DW'(pidaw_pkg::scale_q24(pidaw_pkg::DERIVATIVE_DECAY_RESET_Q24, FRAC_BITS));
    localparam logic [GW-1:0] DERIVATIVE_GAIN_RESET =
        GW'(pidaw_pkg::scale_q24(pidaw_pkg::DERIVATIVE_GAIN_RESET_Q24, FRAC_BITS));
    localparam logic [GW-1:0] WINDUP_GAIN_RESET =
        GW'(pidaw_pkg::scale_q24(pidaw_pkg::WINDUP_GAIN_RESET_Q24, FRAC_BITS));

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W - 1){1'b0}}};

    // configuration
    logic [GW-1:0]                  prop_gain_reg;
    logic [GW-1:0]                  integral_gain_reg;
    logic [DW-1:0]                  derivative_decay_reg;
    logic [GW-1:0]                  derivative_gain_reg;
    logic [GW-1:0]                  windup_gain_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_low_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_high_reg;

    // control and state
    pidaw_pkg::pid_state_t          state_reg, state_next;
    logic                           drive_valid_reg, drive_valid_next;
    logic signed [ACC_W-1:0]        integral_acc_reg, integral_acc_next;
    logic signed [ACC_W-1:0]        deriv_acc_reg, deriv_acc_next;
    logic signed [SAMPLE_WIDTH-1:0] prev_measured_reg, prev_measured_next;

    // datapath
    logic signed [DIF_W-1:0]        err_reg, err_next;
    logic signed [DIF_W-1:0]        dm_reg, dm_next;
    logic signed [ACC_W-1:0]        p_reg, p_next;
    logic signed [ACC_W-1:0]        t_reg, t_next;
    logic signed [ACC_W-1:0]        d_reg, d_next;
    logic signed [ACC_W-1:0]        v_reg, v_next;
    logic signed [ACC_W-1:0]        u_reg, u_next;
    logic signed [ACC_W-1:0]        w_reg, w_next;
    logic signed [SAMPLE_WIDTH-1:0] drive_reg, drive_next;

    // shared adder
    logic signed [ACC_W-1:0]        add_a, add_b, add_sum;
    logic                           add_sub;
    logic signed [ACC_W:0]          add_wide;

    // shared multiplier
    pidaw_pkg::mul_cmd_t            mul_cmd;
    logic signed [ACC_W-1:0]        mul_operand;
    logic [GW-1:0]                  mul_gain;
    logic                           mul_done;
    logic signed [ACC_W-1:0]        mul_result;

    logic signed [ACC_W-1:0]        lo_full, hi_full;

    assign lo_full = ACC_W'(out_low_reg) <<< FRAC_BITS;
    assign hi_full = ACC_W'(out_high_reg) <<< FRAC_BITS;

    assign add_wide = add_sub ? ((ACC_W + 1)'(add_a) - (ACC_W + 1)'(add_b))
                              : ((ACC_W + 1)'(add_a) + (ACC_W + 1)'(add_b));
    assign add_sum  = (add_wide[ACC_W] != add_wide[ACC_W-1])
                      ? (add_wide[ACC_W] ? ACC_MIN : ACC_MAX)
                      : add_wide[ACC_W-1:0];

    pidaw_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (mul_cmd),
        .operand (mul_operand),
        .gain    (mul_gain),
        .done    (mul_done),
        .result  (mul_result)
    );

    assign feedback.ready = (state_reg == pidaw_pkg::ST_IDLE);
    assign actuator.valid = drive_valid_reg;
    assign actuator.drive = drive_reg;

    always_comb
    begin
        state_next         = state_reg;
        drive_valid_next   = drive_valid_reg;
        integral_acc_next  = integral_acc_reg;
        deriv_acc_next     = deriv_acc_reg;
        prev_measured_next = prev_measured_reg;
        err_next           = err_reg;
        dm_next            = dm_reg;
        p_next             = p_reg;
        t_next             = t_reg;
        d_next             = d_reg;
        v_next             = v_reg;
        u_next             = u_reg;
        w_next             = w_reg;
        drive_next         = drive_reg;
        add_a              = '0;
        add_b              = '0;
        add_sub            = 1'b0;
        mul_cmd            = '0;
        mul_operand        = '0;
        mul_gain           = '0;

        if (actuator.ready)
        begin
            drive_valid_next = 1'b0;
        end

        unique case (state_reg)
            pidaw_pkg::ST_IDLE:
            begin
                if (feedback.valid)
                begin
                    err_next = DIF_W'(feedback.setpoint) - DIF_W'(feedback.measured);
                    dm_next  = DIF_W'(feedback.measured) - DIF_W'(prev_measured_reg);
                    prev_measured_next = feedback.measured;
                    state_next = pidaw_pkg::ST_P_GO;
                end
            end
            pidaw_pkg::ST_P_GO:
            begin
                mul_cmd.start = 1'b1;
                mul_operand   = ACC_W'(err_reg);
                mul_gain      = prop_gain_reg;
                state_next    = pidaw_pkg::ST_P_WAIT;
            end
            pidaw_pkg::ST_P_WAIT:
            begin
                if (mul_done)
                begin
                    p_next     = mul_result;
                    state_next = pidaw_pkg::ST_DQ_GO;
                end
            end
            pidaw_pkg::ST_DQ_GO:
            begin
                mul_cmd.start  = 1'b1;
                mul_cmd.scaled = 1'b1;
                mul_operand    = deriv_acc_reg;
                mul_gain       = GW'(derivative_decay_reg);
                state_next     = pidaw_pkg::ST_DQ_WAIT;
            end
            pidaw_pkg::ST_DQ_WAIT:
            begin
                if (mul_done)
                begin
                    t_next     = mul_result;
                    state_next = pidaw_pkg::ST_DI_GO;
                end
            end
            pidaw_pkg::ST_DI_GO:
            begin
                mul_cmd.start = 1'b1;
                mul_operand   = ACC_W'(dm_reg);
                mul_gain      = derivative_gain_reg;
                state_next    = pidaw_pkg::ST_DI_WAIT;
            end
            pidaw_pkg::ST_DI_WAIT:
            begin
                add_a   = t_reg;
                add_b   = mul_result;
                add_sub = 1'b1;
                if (mul_done)
                begin
                    d_next     = add_sum;
                    state_next = pidaw_pkg::ST_V1;
                end
            end
            pidaw_pkg::ST_V1:
            begin
                add_a      = p_reg;
                add_b      = integral_acc_reg;
                v_next     = add_sum;
                state_next = pidaw_pkg::ST_V2;
            end
            pidaw_pkg::ST_V2:
            begin
                add_a          = v_reg;
                add_b          = d_reg;
                v_next         = add_sum;
                deriv_acc_next = d_reg;
                state_next     = pidaw_pkg::ST_CLAMP;
            end
            pidaw_pkg::ST_CLAMP:
            begin
                if (v_reg < lo_full)
                begin
                    u_next = lo_full;
                end
                else if (v_reg > hi_full)
                begin
                    u_next = hi_full;
                end
                else
                begin
                    u_next = v_reg;
                end
                state_next = pidaw_pkg::ST_W;
            end
            pidaw_pkg::ST_W:
            begin
                add_a      = u_reg;
                add_b      = v_reg;
                add_sub    = 1'b1;
                w_next     = add_sum;
                state_next = pidaw_pkg::ST_II_GO;
            end
            pidaw_pkg::ST_II_GO:
            begin
                mul_cmd.start = 1'b1;
                mul_operand   = ACC_W'(err_reg);
                mul_gain      = integral_gain_reg;
                state_next    = pidaw_pkg::ST_II_WAIT;
            end
            pidaw_pkg::ST_II_WAIT:
            begin
                add_a = integral_acc_reg;
                add_b = mul_result;
                if (mul_done)
                begin
                    t_next     = add_sum;
                    state_next = pidaw_pkg::ST_IW_GO;
                end
            end
            pidaw_pkg::ST_IW_GO:
            begin
                mul_cmd.start  = 1'b1;
                mul_cmd.scaled = 1'b1;
                mul_operand    = w_reg;
                mul_gain       = windup_gain_reg;
                state_next     = pidaw_pkg::ST_IW_WAIT;
            end
            pidaw_pkg::ST_IW_WAIT:
            begin
                add_a = t_reg;
                add_b = mul_result;
                if (mul_done)
                begin
                    integral_acc_next = add_sum;
                    state_next        = pidaw_pkg::ST_OUT;
                end
            end
            pidaw_pkg::ST_OUT:
            begin
                if (!drive_valid_reg || actuator.ready)
                begin
                    drive_next       = u_reg[FRAC_BITS +: SAMPLE_WIDTH];
                    drive_valid_next = 1'b1;
                    state_next       = pidaw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pidaw_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= pidaw_pkg::ST_IDLE;
            drive_valid_reg   <= 1'b0;
            integral_acc_reg  <= '0;
            deriv_acc_reg     <= '0;
            prev_measured_reg <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            drive_valid_reg   <= drive_valid_next;
            integral_acc_reg  <= integral_acc_next;
            deriv_acc_reg     <= deriv_acc_next;
            prev_measured_reg <= prev_measured_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg   <= err_next;
        dm_reg    <= dm_next;
        p_reg     <= p_next;
        t_reg     <= t_next;
        d_reg     <= d_next;
        v_reg     <= v_next;
        u_reg     <= u_next;
        w_reg     <= w_next;
        drive_reg <= drive_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg        <= PROP_GAIN_RESET;
            integral_gain_reg    <= INTEGRAL_GAIN_RESET;
            derivative_decay_reg <= DERIVATIVE_DECAY_RESET;
            derivative_gain_reg  <= DERIVATIVE_GAIN_RESET;
            windup_gain_reg      <= WINDUP_GAIN_RESET;
            out_low_reg          <= {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};
            out_high_reg         <= {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
        end
        else if (write_en)
        begin
            unique case (write_index)
                pidaw_pkg::REG_PROP_GAIN:        prop_gain_reg        <= write_data[GW-1:0];
                pidaw_pkg::REG_INTEGRAL_GAIN:    integral_gain_reg    <= write_data[GW-1:0];
                pidaw_pkg::REG_DERIVATIVE_DECAY: derivative_decay_reg <= write_data[DW-1:0];
                pidaw_pkg::REG_DERIVATIVE_GAIN:  derivative_gain_reg  <= write_data[GW-1:0];
                pidaw_pkg::REG_WINDUP_GAIN:      windup_gain_reg      <= write_data[GW-1:0];
                pidaw_pkg::REG_OUT_LOW:
                    out_low_reg <= signed'(write_data[SAMPLE_WIDTH-1:0]);
                pidaw_pkg::REG_OUT_HIGH:
                    out_high_reg <= signed'(write_data[SAMPLE_WIDTH-1:0]);
                default:
                begin
                end
            endcase
        end
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (feedback.valid && feedback.ready) |=> !feedback.ready)
        else $error("feedback accepted again while an item is in flight");

    a_mul_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == pidaw_pkg::ST_P_WAIT || state_reg == pidaw_pkg::ST_DQ_WAIT ||
                      state_reg == pidaw_pkg::ST_DI_WAIT || state_reg == pidaw_pkg::ST_II_WAIT ||
                      state_reg == pidaw_pkg::ST_IW_WAIT))
        else $error("multiplier finished outside a wait step");

    a_clamp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pidaw_pkg::ST_W && lo_full <= hi_full)
        |-> (u_reg >= lo_full && u_reg <= hi_full))
        else $error("clamped value outside drive limits");

    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pidaw_pkg::ST_OUT && actuator.valid && !actuator.ready)
        |=> state_reg == pidaw_pkg::ST_OUT)
        else $error("pending drive overwritten");

    a_deriv_update: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(deriv_acc_reg) |-> $past(state_reg) == pidaw_pkg::ST_V2)
        else $error("derivative state changed outside its update step");

endmodule
